FILE: src/vhdm_pkg.sv
// ----------------------------------------------------------------------------
// vhdm_pkg
// shared types and constants for the voxel hash dedup map
// ----------------------------------------------------------------------------
package vhdm_pkg;

    localparam int KEY_W   = 21;
    localparam int COUNT_W = 17;

    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;

    localparam logic [0:0] ACT_INSERT = 1'b0;
    localparam logic [0:0] ACT_READ   = 1'b1;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_CAP     = 3'd2;
    localparam logic [2:0] ST_PROBES  = 3'd3;
    localparam logic [2:0] ST_VALID   = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    localparam logic [0:0] CFG_INV_LEAF   = 1'b0;
    localparam logic [0:0] CFG_MAX_VOXELS = 1'b1;

    typedef struct packed {
        logic [0:0]         action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        intensity;
        logic [15:0]        slot_index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [16:0]        voxel_count;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [15:0]        out_intensity;
    } out_word_t;

    // classified job passed from front to back
    typedef struct packed {
        logic         is_read;
        logic         read_oor;
        logic [63:0]  hash;
        logic [62:0]  key;
        logic [31:0]  px;
        logic [31:0]  py;
        logic [31:0]  pz;
        logic [15:0]  pi;
        logic [19:0]  slot;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD,
        B_WAIT,
        B_CHECK,
        B_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_HASH,
        F_PUSH
    } front_state_t;

endpackage

FILE: src/vhdm_front.sv
// ----------------------------------------------------------------------------
// vhdm_front
// quantizes a point to a voxel key and hashes it, one item at a time
// ----------------------------------------------------------------------------
module vhdm_front
    import vhdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    input  logic [15:0] inv_leaf_size,
    output logic      job_valid,
    input  logic      job_full,
    output job_t      job
);

    front_state_t state_reg, state_next;
    in_word_t     item_reg;
    logic signed [48:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic [63:0] hx_reg, hy_reg, hz_reg;
    logic [62:0] key_reg;

    function automatic logic [KEY_W-1:0] quant(input logic signed [48:0] p);
        logic signed [48:0] q;
        begin
            q = p >>> 24; // arithmetic shift is floor
            if (q > 49'sd1048575)
                quant = 21'h0FFFFF;
            else if (q < -49'sd1048576)
                quant = 21'h100000;
            else
                quant = q[KEY_W-1:0];
        end
    endfunction

    logic [KEY_W-1:0] kx, ky, kz;
    assign kx = quant(prod_x_reg);
    assign ky = quant(prod_y_reg);
    assign kz = quant(prod_z_reg);

    // primes fit in 27 bits, so key times prime fits a signed 48-bit product
    logic signed [47:0] mx, my, mz;
    assign mx = $signed(kx) * $signed({1'b0, HASH_PX[26:0]});
    assign my = $signed(ky) * $signed({1'b0, HASH_PY[26:0]});
    assign mz = $signed(kz) * $signed({1'b0, HASH_PZ[26:0]});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (in_valid) state_next = F_MUL;
            F_MUL:  state_next = F_HASH;
            F_HASH: state_next = F_PUSH;
            F_PUSH: if (!job_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != F_IDLE);
        job_valid = (state_reg == F_PUSH);
        job.is_read  = (item_reg.action == ACT_READ);
        job.read_oor = 1'b0;
        job.hash     = hx_reg ^ hy_reg ^ hz_reg;
        job.key      = key_reg;
        job.px       = item_reg.pos_x;
        job.py       = item_reg.pos_y;
        job.pz       = item_reg.pos_z;
        job.pi       = item_reg.intensity;
        job.slot     = 20'(item_reg.slot_index);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
            item_reg <= in_word;
        if (state_reg == F_MUL)
        begin
            prod_x_reg <= item_reg.pos_x * $signed({1'b0, inv_leaf_size});
            prod_y_reg <= item_reg.pos_y * $signed({1'b0, inv_leaf_size});
            prod_z_reg <= item_reg.pos_z * $signed({1'b0, inv_leaf_size});
        end
        if (state_reg == F_HASH)
        begin
            // sign-extended key times prime, 64-bit wrap
            hx_reg  <= {{16{mx[47]}}, mx};
            hy_reg  <= {{16{my[47]}}, my};
            hz_reg  <= {{16{mz[47]}}, mz};
            key_reg <= {kx, ky, kz};
        end
    end

endmodule

FILE: src/vhdm_queue.sv
// ----------------------------------------------------------------------------
// vhdm_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module vhdm_queue
    import vhdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full) wp_reg <= ~wp_reg;
            if (pop && not_empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && not_empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_job;
    end

endmodule

FILE: src/vhdm_back.sv
// ----------------------------------------------------------------------------
// vhdm_back
// probes the slot table, inserts or updates, reads slots
// ----------------------------------------------------------------------------
module vhdm_back
    import vhdm_pkg::*;
#(
    parameter int CAPACITY    = 65536,
    parameter int PROBE_LIMIT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    input  logic [16:0] max_voxels,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);

    back_state_t state_reg, state_next;

    logic [62:0]  key_mem [CAPACITY];
    logic [111:0] pt_mem  [CAPACITY];

    logic [SLOT_W-1:0]  slot_reg;
    logic [PROBE_W-1:0] probe_reg;
    logic [SLOT_W:0]    clr_reg;
    logic               valid_q_reg;
    logic [62:0]        key_q_reg;
    logic [111:0]       pt_q_reg;
    logic [16:0]        count_reg;
    out_word_t          out_reg;

    // valid bits in a memory of their own, cleared by a sweep after reset
    logic vmem [CAPACITY];

    logic clearing;
    logic cap_hit;
    logic last_probe;
    logic is_oor;

    assign clearing   = !clr_reg[SLOT_W];
    assign cap_hit    = (max_voxels != 17'd0) && (count_reg >= max_voxels);
    assign last_probe = (probe_reg == PROBE_W'(PROBE_LIMIT - 1));
    assign is_oor     = ({1'b0, job.slot} >= 21'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (job_valid && !clearing) state_next = B_RD;
            B_RD:    state_next = B_WAIT;
            B_WAIT:  state_next = B_CHECK;
            B_CHECK:
            begin
                if (job.is_read || !valid_q_reg || key_q_reg == job.key || last_probe)
                    state_next = B_OUT;
                else
                    state_next = B_RD;
            end
            B_OUT:   if (!out_stall) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop   = (state_reg == B_OUT) && !out_stall;
        out_valid = (state_reg == B_OUT);
        out_word  = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == B_CHECK && !job.is_read && !(valid_q_reg &&
                key_q_reg == job.key) && !cap_hit && !valid_q_reg)
                count_reg <= count_reg + 1'b1;
        end
    end

    // probe address and result
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            probe_reg <= '0;
            if (job.is_read)
                slot_reg <= job.slot[SLOT_W-1:0];
            else
                slot_reg <= job.hash[SLOT_W-1:0];
        end
        else if (state_reg == B_CHECK)
        begin
            probe_reg <= probe_reg + 1'b1;
            slot_reg  <= slot_reg + 1'b1;
        end
        if (state_reg == B_CHECK)
        begin
            out_reg <= '0;
            if (job.is_read)
            begin
                if (valid_q_reg && !is_oor)
                begin
                    out_reg.status        <= ST_VALID;
                    out_reg.out_x         <= pt_q_reg[111:80];
                    out_reg.out_y         <= pt_q_reg[79:48];
                    out_reg.out_z         <= pt_q_reg[47:16];
                    out_reg.out_intensity <= pt_q_reg[15:0];
                end
                else
                    out_reg.status <= ST_EMPTY;
                out_reg.voxel_count <= count_reg;
            end
            else if (valid_q_reg && key_q_reg == job.key)
            begin
                out_reg.status      <= ST_UPDATED;
                out_reg.voxel_count <= count_reg;
            end
            else if (cap_hit && (!valid_q_reg || last_probe))
            begin
                out_reg.status      <= ST_CAP;
                out_reg.voxel_count <= count_reg;
            end
            else if (!valid_q_reg)
            begin
                out_reg.status      <= ST_NEW;
                out_reg.voxel_count <= count_reg + 1'b1;
            end
            else
            begin
                out_reg.status      <= ST_PROBES;
                out_reg.voxel_count <= count_reg;
            end
        end
    end

    // table memories: one read and one write port each
    always_ff @(posedge clk)
    begin
        if (state_reg == B_RD)
        begin
            valid_q_reg <= vmem[slot_reg];
            key_q_reg   <= key_mem[slot_reg];
            pt_q_reg    <= pt_mem[slot_reg];
        end
        if (clearing)
            vmem[clr_reg[SLOT_W-1:0]] <= 1'b0;
        else if (state_reg == B_CHECK && !job.is_read && !valid_q_reg && !cap_hit)
            vmem[slot_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_CHECK && !job.is_read && !valid_q_reg && !cap_hit)
            key_mem[slot_reg] <= job.key;
        if (state_reg == B_CHECK && !job.is_read &&
            ((valid_q_reg && key_q_reg == job.key) || (!valid_q_reg && !cap_hit)))
            pt_mem[slot_reg] <= {job.px, job.py, job.pz, job.pi};
    end

endmodule

FILE: src/voxel_hash_dedup_map_top.sv
// ----------------------------------------------------------------------------
// voxel_hash_dedup_map_top
// voxel grid spatial hash map with point deduplication
// ----------------------------------------------------------------------------
// After reset the block sweeps its valid table, one slot a cycle (CAPACITY
// slots, 65536 by default), before the back stage takes jobs. The front stage
// quantizes and hashes one point through the states F_IDLE, F_MUL, F_HASH and
// F_PUSH; the back stage takes the job in B_IDLE, passes B_RD, B_WAIT and
// B_CHECK for each probed slot through the single registered read port of each
// table memory (up to PROBE_LIMIT slots for an insert, one for a read), and ends
// in B_OUT. Front and back are joined by a two-entry queue so hashing overlaps probing.
module voxel_hash_dedup_map_top
    import vhdm_pkg::*;
#(
    parameter int CAPACITY    = 65536,
    parameter int PROBE_LIMIT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    logic [15:0] inv_leaf_reg;
    logic [16:0] max_vox_reg;
    logic        fj_valid, q_full, q_pop, q_ne;
    job_t        fj, qh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_leaf_reg <= 16'd2560;
            max_vox_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INV_LEAF:   inv_leaf_reg <= cfg_data[15:0];
                CFG_MAX_VOXELS: max_vox_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    vhdm_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_word,
        .inv_leaf_size(inv_leaf_reg),
        .job_valid(fj_valid), .job_full(q_full), .job(fj)
    );

    vhdm_queue u_queue (
        .clk, .rst_n, .push(fj_valid), .push_job(fj), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(qh)
    );

    vhdm_back #(.CAPACITY(CAPACITY), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
        .clk, .rst_n, .job_valid(q_ne), .job(qh), .job_pop(q_pop),
        .max_voxels(max_vox_reg), .out_valid, .out_stall, .out_word
    );

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.status <= ST_EMPTY)
        else $error("status out of range");

    a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status != ST_VALID) |->
        (out_word.out_x == 0 && out_word.out_intensity == 0))
        else $error("nonzero point on non-read result");

    a_pop_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_ne && out_valid))
        else $error("queue popped without result");

endmodule

FILE: tb/vhdm_checker.sv
// ----------------------------------------------------------------------------
// vhdm_checker
// watches both channels and the register port of the voxel hash map, keeps
// its own copy of the slot table, predicts each result word and compares
// ----------------------------------------------------------------------------
module vhdm_checker
    import vhdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_word_t    in_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_word_t   out_word,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        eot,
    output int          fails
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]  leaf_inv;
    logic [16:0]  voxel_cap;
    logic [16:0]  voxel_total;
    logic         occupied [65536];
    logic [62:0]  slot_keys [65536];
    logic [31:0]  slot_x [65536];
    logic [31:0]  slot_y [65536];
    logic [31:0]  slot_z [65536];
    logic [15:0]  slot_int [65536];
    out_word_t    pending_words [$];
    logic         eot_done;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fails++;
    endtask

    // floor(coord * inv / 2^24), clamped to signed 21 bits
    function automatic logic signed [20:0] voxel_of(logic signed [31:0] c, logic [15:0] inv);
        logic signed [63:0] prod;
        logic signed [63:0] q;
        prod = c * $signed({1'b0, inv});
        q = prod >>> 24;
        if (q > 64'sd1048575)
            q = 64'sd1048575;
        else if (q < -64'sd1048576)
            q = -64'sd1048576;
        return q[20:0];
    endfunction

    function automatic out_word_t apply_word(in_word_t w);
        out_word_t         r;
        logic signed [20:0] kx, ky, kz;
        logic [62:0]       key;
        logic [63:0]       h;
        logic [15:0]       home, s, slot;
        logic              found, empty_seen, stop;
        r = '0;
        if (w.action == ACT_READ) begin
            if (occupied[w.slot_index]) begin
                r.status        = ST_VALID;
                r.out_x         = slot_x[w.slot_index];
                r.out_y         = slot_y[w.slot_index];
                r.out_z         = slot_z[w.slot_index];
                r.out_intensity = slot_int[w.slot_index];
            end
            else
                r.status = ST_EMPTY;
        end
        else begin
            kx = voxel_of(w.pos_x, leaf_inv);
            ky = voxel_of(w.pos_y, leaf_inv);
            kz = voxel_of(w.pos_z, leaf_inv);
            key = {kx, ky, kz};
            h = ({{43{kx[20]}}, kx} * {32'd0, HASH_PX})
              ^ ({{43{ky[20]}}, ky} * {32'd0, HASH_PY})
              ^ ({{43{kz[20]}}, kz} * {32'd0, HASH_PZ});
            home = h[15:0];
            found = 1'b0;
            empty_seen = 1'b0;
            stop = 1'b0;
            slot = '0;
            for (int p = 0; p < 8; p++) begin
                if (!stop) begin
                    s = home + 16'(p);
                    if (!occupied[s]) begin
                        empty_seen = 1'b1;
                        slot = s;
                        stop = 1'b1;
                    end
                    else if (slot_keys[s] == key) begin
                        found = 1'b1;
                        slot = s;
                        stop = 1'b1;
                    end
                end
            end
            if (found)
                r.status = ST_UPDATED;
            else if (voxel_cap != 0 && voxel_total >= voxel_cap)
                r.status = ST_CAP;
            else if (!empty_seen)
                r.status = ST_PROBES;
            else begin
                r.status = ST_NEW;
                occupied[slot] = 1'b1;
                slot_keys[slot] = key;
                voxel_total = voxel_total + 1'b1;
            end
            if (r.status == ST_NEW || r.status == ST_UPDATED) begin
                slot_x[slot]   = w.pos_x;
                slot_y[slot]   = w.pos_y;
                slot_z[slot]   = w.pos_z;
                slot_int[slot] = w.intensity;
            end
        end
        r.voxel_count = voxel_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        out_word_t want;
        if (!rst_n) begin
            leaf_inv    <= 16'd2560;
            voxel_cap   <= '0;
            voxel_total = '0;
            for (int i = 0; i < 65536; i++)
                occupied[i] = 1'b0;
            pending_words.delete();
            eot_done <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_INV_LEAF)
                    leaf_inv <= cfg_data[15:0];
                else if (cfg_index == CFG_MAX_VOXELS)
                    voxel_cap <= cfg_data;
            end
            if (out_valid && !out_stall) begin
                if (pending_words.size() == 0)
                    report("unexpected word", 64'(out_word.status), 64'd0);
                else begin
                    want = pending_words.pop_front();
                    if (out_word.status != want.status)
                        report("status", 64'(out_word.status), 64'(want.status));
                    if (out_word.voxel_count != want.voxel_count)
                        report("voxel_count", 64'(out_word.voxel_count),
                               64'(want.voxel_count));
                    if (out_word.out_x != want.out_x)
                        report("out_x", 64'(out_word.out_x), 64'(want.out_x));
                    if (out_word.out_y != want.out_y)
                        report("out_y", 64'(out_word.out_y), 64'(want.out_y));
                    if (out_word.out_z != want.out_z)
                        report("out_z", 64'(out_word.out_z), 64'(want.out_z));
                    if (out_word.out_intensity != want.out_intensity)
                        report("out_intensity", 64'(out_word.out_intensity),
                               64'(want.out_intensity));
                end
            end
            if (in_valid && !in_stall)
                pending_words.insert(pending_words.size(), apply_word(in_word));
            if (eot && !eot_done) begin
                eot_done <= 1'b1;
                while (pending_words.size() != 0) begin
                    want = pending_words.pop_front();
                    report("missing word", 64'd0, 64'(want.status));
                end
            end
        end
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the voxel hash dedup map: directed corner points,
// hash chain collisions, cap and leaf size settings, then random phases with
// sender gaps and receiver stalls; the checker does all the comparing
// ----------------------------------------------------------------------------
module tb;
    import vhdm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_INV_LEAF;
    logic [16:0] cfg_data = '0;
    logic        eot = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          fails;
    int          sent = 0;
    int          received = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    voxel_hash_dedup_map_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vhdm_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .eot(eot), .fails(fails)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            received <= received + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic in_word_t mk(logic [0:0] act, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z, logic [15:0] inten, logic [15:0] slot);
        in_word_t w;
        w.action = act;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        w.intensity = inten;
        w.slot_index = slot;
        return w;
    endfunction

    // home slot of voxel (kx,0,0): only the low 16 bits of kx*PX matter
    function automatic logic [15:0] chain_home(logic [31:0] kx);
        logic [31:0] prod;
        prod = kx * HASH_PX;
        return prod[15:0];
    endfunction

    // at leaf inverse 8192 the voxel x index is raw/2048, and y,z below 2048 stay in voxel 0
    function automatic in_word_t rand_word();
        in_word_t    w;
        int          sel;
        logic [31:0] kx;
        sel = $urandom_range(99);
        w = mk(ACT_INSERT, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
        if (sel < 35) begin
            kx = $urandom_range(3) + $urandom_range(15) * 65536;
            w.pos_x = kx * 2048 + $urandom_range(2047);
            w.pos_y = $urandom_range(2047);
            w.pos_z = $urandom_range(2047);
        end
        else if (sel < 55) begin
            w.pos_x = $urandom_range(1023) * 2048 + $urandom_range(2047);
            w.pos_y = $urandom_range(2047);
            w.pos_z = $urandom_range(2047);
            if ($urandom_range(1))
                w.pos_y = -w.pos_y;
        end
        else if (sel < 70) begin
            // fully random point
        end
        else if (sel < 88) begin
            w.action = ACT_READ;
            if ($urandom_range(1))
                w.slot_index = 16'(chain_home($urandom_range(3)) + $urandom_range(8));
            else
                w.slot_index = 16'(chain_home($urandom_range(1023)) + $urandom_range(1));
        end
        else
            w.action = ACT_READ;
        return w;
    endfunction

    task automatic send(input in_word_t w);
        bit go;
        if (idle_pct != 0)
            while ($urandom_range(99) < idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_word <= w;
        go = 1'b0;
        while (!go) begin
            @(negedge clk);
            go = !in_stall;
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (received != sent)
            @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [16:0] d);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (n) send(rand_word());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: origin, update, extremes, reads
        send(mk(ACT_INSERT, 32'h0, 32'h0, 32'h0, 16'h0000, 16'h0));
        send(mk(ACT_INSERT, 32'h10, 32'h20, 32'h30, 16'hffff, 16'hffff));
        send(mk(ACT_INSERT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h1234, 16'h0));
        send(mk(ACT_INSERT, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8001, 16'h0));
        send(mk(ACT_READ, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'h0000));
        send(mk(ACT_READ, 32'h0, 32'h0, 32'h0, 16'h0, 16'hffff));

        // nine voxels sharing one home: eight fill the run, the ninth runs out of probes
        write_reg(CFG_INV_LEAF, 17'd8192);
        for (int j = 0; j < 9; j++)
            send(mk(ACT_INSERT, (5 + j * 65536) * 2048, 32'h0, 32'h0, 16'(j), 16'h0));
        send(mk(ACT_INSERT, (5 + 2 * 65536) * 2048 + 7, 32'h5, 32'h9, 16'hbeef, 16'h0));
        send(mk(ACT_READ, 32'h0, 32'h0, 32'h0, 16'h0, chain_home(5)));
        send(mk(ACT_READ, 32'h0, 32'h0, 32'h0, 16'h0, chain_home(5) + 16'd7));

        // largest leaf inverse saturates the voxel index
        write_reg(CFG_INV_LEAF, 17'd65535);
        write_reg(CFG_MAX_VOXELS, 17'd65536);
        send(mk(ACT_INSERT, 32'h7fffffff, 32'h80000000, 32'h00000001, 16'h5a5a, 16'h0));

        // zero leaf inverse: everything lands in voxel origin
        write_reg(CFG_INV_LEAF, 17'd0);
        send(mk(ACT_INSERT, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 16'h4321, 16'h0));

        // cap reached: new voxel refused even though probes are exhausted too
        write_reg(CFG_MAX_VOXELS, 17'd1);
        write_reg(CFG_INV_LEAF, 17'd8192);
        send(mk(ACT_INSERT, (5 + 9 * 65536) * 2048, 32'h0, 32'h0, 16'h7777, 16'h0));
        send(mk(ACT_INSERT, (5 + 4 * 65536) * 2048, 32'h0, 32'h0, 16'h6666, 16'h0));

        write_reg(CFG_MAX_VOXELS, 17'd0);
        hold_req <= 1'b1;
        random_phase(190, 0, 0);
        write_reg(CFG_MAX_VOXELS, 17'd65536);
        random_phase(190, 83, 0);
        write_reg(CFG_INV_LEAF, 17'd1);
        write_reg(CFG_MAX_VOXELS, 17'd0);
        random_phase(190, 0, 83);
        write_reg(CFG_INV_LEAF, 17'd65535);
        write_reg(CFG_MAX_VOXELS, 17'd300);
        random_phase(190, 32, 32);

        drain();
        eot <= 1'b1;
        repeat (2) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: voxel_hash_dedup_map_top.f
src/vhdm_pkg.sv
src/vhdm_front.sv
src/vhdm_queue.sv
src/vhdm_back.sv
src/voxel_hash_dedup_map_top.sv
tb/vhdm_checker.sv
tb/tb.sv
